// ===== sv/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg: shared definitions for the positional list engine
// Operation codes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 7;
    localparam int STAT_W       = 2;

    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } t_state;

endpackage

// ===== sv/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Insert, delete and read by position over a packed entry RAM.
// ----------------------------------------------------------------------------
// The list is held packed in one RAM of CAPACITY entries; position 1 is entry
// 0. A request is taken only while the sequencer is idle. A refused or flagged
// request passes through S_DONE into the output register, a read through
// S_RDWAIT and S_DONE; the next request can be taken in the same cycle as the result appears.
// An insert or a delete moves the entries behind the target position one
// place, one RAM read and one RAM write per cycle; it moves count - position
// + 1 entries for an insert and count - position for a delete. An insert
// passes through S_SHIFT, S_PUT and S_DONE, a delete through S_SHIFT and
// S_DONE; the longest is an insert at the front of a list one short of full.
// The result is held in an output register, and a finished result waits there
// while the next request is taken; a result that finds the register still
// occupied holds the sequencer until it frees.
module positional_list_engine
    import plm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [OP_W-1:0]                   i_operation,
    input  logic signed [DATA_W-1:0]          i_value,
    input  logic [POS_W-1:0]                  i_position,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [STAT_W-1:0]                 o_status,
    output logic [$clog2(CAPACITY+1)-1:0]     o_count,
    output logic signed [DATA_W-1:0]          o_read_value
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [AW-1:0]      r_rptr, n_rptr;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic               r_pend, n_pend;
    logic               r_up, n_up;
    logic               r_ins, n_ins;
    logic [DATA_W-1:0]  r_val, n_val;
    logic [STAT_W-1:0]  r_st, n_st;
    logic [DATA_W-1:0]  r_rdval, n_rdval;
    logic               r_ovalid, n_ovalid;
    logic [STAT_W-1:0]  r_ostat, n_ostat;
    logic [CNT_W-1:0]   r_ocount, n_ocount;
    logic [DATA_W-1:0]  r_odata, n_odata;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    // request decode
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic               full;
    logic               empty;
    logic               is_ins, is_del, is_rd;
    logic [STAT_W-1:0]  dec_st;
    logic [CNT_W-1:0]   dec_idx;
    logic               in_acc;

    plm_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        pos_x   = CMP_W'(i_position);
        cnt_x   = CMP_W'(r_count);
        full    = (r_count == CNT_W'(CAPACITY));
        empty   = (r_count == '0);
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_rd   = 1'b0;
        dec_st  = ST_OK;
        dec_idx = CNT_W'(pos_x - CMP_W'(1));
        case (i_operation)
            OP_INS_FIRST: begin
                is_ins  = 1'b1;
                dec_idx = '0;
                if (full) dec_st = ST_FULL;
            end
            OP_INS_LAST: begin
                is_ins  = 1'b1;
                dec_idx = r_count;
                if (full) dec_st = ST_FULL;
            end
            OP_INS_AT: begin
                is_ins = 1'b1;
                if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                    dec_st = ST_BADPOS;
                end else if (full) begin
                    dec_st = ST_FULL;
                end
            end
            OP_DEL_FIRST: begin
                is_del  = 1'b1;
                dec_idx = '0;
                if (empty) dec_st = ST_EMPTY;
            end
            OP_DEL_LAST: begin
                is_del  = 1'b1;
                dec_idx = r_count - CNT_W'(1);
                if (empty) dec_st = ST_EMPTY;
            end
            OP_DEL_AT: begin
                is_del = 1'b1;
                if (pos_x == '0 || pos_x > cnt_x) dec_st = ST_BADPOS;
            end
            OP_READ_AT: begin
                is_rd = 1'b1;
                if (pos_x == '0 || pos_x > cnt_x) dec_st = ST_BADPOS;
            end
            default: begin
                dec_st = ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_left    = r_left;
        n_rptr    = r_rptr;
        n_paddr   = r_paddr;
        n_pend    = r_pend;
        n_up      = r_up;
        n_ins     = r_ins;
        n_val     = r_val;
        n_st      = r_st;
        n_rdval   = r_rdval;
        n_ovalid  = r_ovalid && !i_ready;
        n_ostat   = r_ostat;
        n_ocount  = r_ocount;
        n_odata   = r_odata;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = r_rptr;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_st    = dec_st;
                    n_rdval = '0;
                    n_idx   = dec_idx;
                    n_val   = i_value;
                    n_state = S_DONE;
                    if (dec_st == ST_OK) begin
                        if (is_ins) begin
                            n_count = r_count + CNT_W'(1);
                            n_left  = r_count - dec_idx;
                            n_rptr  = AW'(r_count - CNT_W'(1));
                            n_up    = 1'b1;
                            n_ins   = 1'b1;
                            n_state = S_SHIFT;
                        end else if (is_del) begin
                            n_count = r_count - CNT_W'(1);
                            n_left  = r_count - CNT_W'(1) - dec_idx;
                            n_rptr  = AW'(dec_idx + CNT_W'(1));
                            n_up    = 1'b0;
                            n_ins   = 1'b0;
                            n_state = S_SHIFT;
                        end else if (is_rd) begin
                            mem_raddr = AW'(dec_idx);
                            n_state   = S_RDWAIT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place over
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_up ? r_paddr + AW'(1) : r_paddr - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_left != '0) begin
                    mem_raddr = r_rptr;
                    n_paddr   = r_rptr;
                    n_rptr    = r_up ? r_rptr - AW'(1) : r_rptr + AW'(1);
                    n_left    = r_left - CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) n_state = r_ins ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx);
                mem_wdata = r_val;
                n_state   = S_DONE;
            end
            S_RDWAIT: begin
                n_rdval = mem_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_st;
                    n_ocount = r_count;
                    n_odata  = r_rdval;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rptr   <= n_rptr;
        r_paddr  <= n_paddr;
        r_up     <= n_up;
        r_ins    <= n_ins;
        r_val    <= n_val;
        r_st     <= n_st;
        r_rdval  <= n_rdval;
        r_ostat  <= n_ostat;
        r_ocount <= n_ocount;
        r_odata  <= n_odata;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_count      = r_ocount;
    assign o_read_value = r_odata;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> r_count == $past(r_count))
        else $error("entry count changed without a request");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend && r_left == '0)
        else $error("idle with a shift read outstanding");

    a_shift_exit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT && n_state != S_SHIFT |-> !r_pend && r_left == '0)
        else $error("shift left with entries still to move");
`endif

endmodule

// ===== sv/plm_ram.sv =====
// ----------------------------------------------------------------------------
// plm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
